// File: rtl/b32d_pkg.sv
// Package for the base32 decoder: character codes, queue sizing and the
// queue entry and status types. Depends on nothing.
`timescale 1ns / 1ps

package b32d_pkg;

	// Character codes of the accepted alphabet.
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_DIGIT_2 = 8'h32;
	localparam logic [7:0] CHAR_DIGIT_7 = 8'h37;

	// Value of the digit '2'; digits '2'..'7' follow the 26 letters.
	localparam logic [4:0] DIGIT_BASE_VALUE = 5'd26;

	// Queue between the classifier and the bit packer.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// One classified character.
	typedef struct packed {
		logic [4:0] value;
		logic       invalid;
		logic       last;
	} sym_entry_t;

	// Queue fill status seen by both sides.
	typedef struct packed {
		logic                   full;
		logic                   empty;
		logic [QUEUE_CNT_W-1:0] count;
	} queue_status_t;

endpackage

// File: rtl/b32d_front.sv
// Front end of the base32 decoder: input handshake, case mode register and
// character classification. Depends on b32d_pkg.
`timescale 1ns / 1ps

module b32d_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic                   cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             symbol,
	input  logic                   last_symbol,
	input  b32d_pkg::queue_status_t q_status,
	output logic                   push,
	output b32d_pkg::sym_entry_t   push_entry
);

	logic upper_mode_q;
	logic is_digit;
	logic is_upper;
	logic is_lower;

	// Case mode register; a new mode applies from the next character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_mode_q <= 1'b0;
		end else if (cfg_wen) begin
			upper_mode_q <= cfg_wdata;
		end
	end

	// The input waits only while the queue has no free slot.
	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	// Map the character to its 5-bit value and flag anything outside the alphabet.
	always_comb begin
		is_digit = (symbol >= b32d_pkg::CHAR_DIGIT_2) && (symbol <= b32d_pkg::CHAR_DIGIT_7);
		is_upper = (symbol >= b32d_pkg::CHAR_UPPER_A) && (symbol <= b32d_pkg::CHAR_UPPER_Z);
		is_lower = (symbol >= b32d_pkg::CHAR_LOWER_A) && (symbol <= b32d_pkg::CHAR_LOWER_Z);
		push_entry.last    = last_symbol;
		push_entry.invalid = 1'b0;
		priority if (is_digit) begin
			push_entry.value = 5'(symbol - b32d_pkg::CHAR_DIGIT_2) + b32d_pkg::DIGIT_BASE_VALUE;
		end else if (upper_mode_q && is_upper) begin
			push_entry.value = 5'(symbol - b32d_pkg::CHAR_UPPER_A);
		end else if (!upper_mode_q && is_lower) begin
			push_entry.value = 5'(symbol - b32d_pkg::CHAR_LOWER_A);
		end else begin
			push_entry.value   = 5'd0;
			push_entry.invalid = 1'b1;
		end
	end

endmodule

// File: rtl/b32d_queue.sv
// Short register queue of classified characters between front and back end.
// Depends on b32d_pkg.
`timescale 1ns / 1ps

module b32d_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  b32d_pkg::sym_entry_t    push_entry,
	input  logic                    pop,
	output b32d_pkg::sym_entry_t    pop_entry,
	output b32d_pkg::queue_status_t status
);

	b32d_pkg::sym_entry_t entries_q [b32d_pkg::QUEUE_DEPTH];
	logic [b32d_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [b32d_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [b32d_pkg::QUEUE_CNT_W-1:0] count_q;

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == b32d_pkg::QUEUE_PTR_W'(b32d_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == b32d_pkg::QUEUE_PTR_W'(b32d_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign pop_entry    = entries_q[rd_ptr_q];
	assign status.full  = (count_q == b32d_pkg::QUEUE_CNT_W'(b32d_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign status.count = count_q;

endmodule

// File: rtl/b32d_back.sv
// Back end of the base32 decoder: bit packer, sticky error and the output
// register. Depends on b32d_pkg.
`timescale 1ns / 1ps

module b32d_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  b32d_pkg::queue_status_t q_status,
	input  b32d_pkg::sym_entry_t    pop_entry,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [7:0]              data_byte,
	output logic                    byte_valid,
	output logic                    end_of_string,
	output logic                    bad_symbol
);

	logic [6:0]  leftover_q;
	logic [2:0]  count_q;
	logic        error_q;
	logic        out_valid_q;
	logic [7:0]  data_byte_q;
	logic        byte_valid_q;
	logic        eos_q;
	logic        bad_q;

	logic [11:0] bits_cat;
	logic [3:0]  cnt_sum;
	logic [2:0]  rest;
	logic        err_n;
	logic [7:0]  byte_n;
	logic        bval_n;
	logic [6:0]  leftover_n;
	logic [2:0]  count_n;

	// Pop when the queue is not empty and the output register is free or emptying.
	assign pop = !q_status.empty && (!out_valid_q || !out_stall);

	// Append five bits and extract a byte once eight are pending; an error stops both.
	always_comb begin
		bits_cat   = {leftover_q, pop_entry.value};
		cnt_sum    = {1'b0, count_q} + 4'd5;
		rest       = 3'(cnt_sum - 4'd8);
		err_n      = error_q || pop_entry.invalid;
		byte_n     = 8'd0;
		bval_n     = 1'b0;
		leftover_n = leftover_q;
		count_n    = count_q;
		if (!err_n) begin
			if (cnt_sum >= 4'd8) begin
				byte_n     = 8'(bits_cat >> rest);
				bval_n     = 1'b1;
				leftover_n = bits_cat[6:0] & 7'((7'd1 << rest) - 7'd1);
				count_n    = rest;
			end else begin
				leftover_n = bits_cat[6:0];
				count_n    = cnt_sum[2:0];
			end
		end
	end

	// String state; the last character of a string clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leftover_q  <= '0;
			count_q     <= '0;
			error_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (pop_entry.last) begin
					leftover_q <= '0;
					count_q    <= '0;
					error_q    <= 1'b0;
				end else begin
					leftover_q <= leftover_n;
					count_q    <= count_n;
					error_q    <= err_n;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (pop) begin
			data_byte_q  <= byte_n;
			byte_valid_q <= bval_n;
			eos_q        <= pop_entry.last;
			bad_q        <= err_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign data_byte     = data_byte_q;
	assign byte_valid    = byte_valid_q;
	assign end_of_string = eos_q;
	assign bad_symbol    = bad_q;

endmodule

// File: rtl/base32_decoder_top.sv
// Top level of the base32 decoder: front end, queue and back end.
// Depends on b32d_pkg, b32d_front, b32d_queue and b32d_back.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_stall    symbol, last_symbol
//   out      out_valid/out_stall  data_byte, byte_valid, end_of_string, bad_symbol
//   cfg      cfg_wen              cfg_wdata (upper case mode)
//
// One character per cycle is sustained while the output is not stalled;
// each result passes through the queue register and then the output register.
// Reset clears the queue, string state and case mode; no clearing pass.
// Output stalls back up into the four-entry queue; the input stalls only
// when the queue is full.
`timescale 1ns / 1ps

module base32_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	input  logic       last_symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       end_of_string,
	output logic       bad_symbol
);

	b32d_pkg::queue_status_t q_status;
	b32d_pkg::sym_entry_t    push_entry;
	b32d_pkg::sym_entry_t    pop_entry;
	logic                    push;
	logic                    pop;

	// Classify characters into the queue.
	b32d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.symbol     (symbol),
		.last_symbol(last_symbol),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decouple the two halves.
	b32d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.pop_entry (pop_entry),
		.status    (q_status)
	);

	// Pack bits into bytes and present results.
	b32d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.pop_entry    (pop_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.end_of_string(end_of_string),
		.bad_symbol   (bad_symbol)
	);

`ifndef SYNTHESIS
	// A string with an error never delivers a byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(byte_valid && bad_symbol))
		else $error("byte delivered after an invalid character");

	// A result without a byte carries a zero data byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (data_byte == 8'd0))
		else $error("nonzero data byte without byte_valid");

	// The queue never overfills and never pops when empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_status.count <= b32d_pkg::QUEUE_CNT_W'(b32d_pkg::QUEUE_DEPTH))
		&& !(pop && q_status.empty) && !(push && q_status.full))
		else $error("queue overflow or underflow");
`endif

endmodule
